/* rtl/hpk_pkg.sv */
package hpk_pkg;

  localparam int unsigned CodeW = 30;
  localparam int unsigned LenW  = 5;
  localparam int unsigned AccW  = 37;
  localparam int unsigned CntW  = 6;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } rom_entry_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       code_last;
  } out_beat_t;

  localparam logic [CodeW-1:0] HuffCode [256] = '{
    30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3, 30'hfffffe4, 30'hfffffe5,
    30'hfffffe6, 30'hfffffe7, 30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9,
    30'hfffffea, 30'h3ffffffd, 30'hfffffeb, 30'hfffffec, 30'hfffffed, 30'hfffffee,
    30'hfffffef, 30'hffffff0, 30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3,
    30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7, 30'hffffff8, 30'hffffff9,
    30'hffffffa, 30'hffffffb, 30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15,
    30'hf8, 30'h7fa, 30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17,
    30'h18, 30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d, 30'h1e,
    30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc, 30'h1ffa, 30'h21,
    30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62, 30'h63, 30'h64, 30'h65, 30'h66,
    30'h67, 30'h68, 30'h69, 30'h6a, 30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70,
    30'h71, 30'h72, 30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc,
    30'h22, 30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26, 30'h27,
    30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7, 30'h2b, 30'h76, 30'h2c,
    30'h8, 30'h9, 30'h2d, 30'h77, 30'h78, 30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc,
    30'h3ffd, 30'h1ffd, 30'hffffffc, 30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8,
    30'h3fffd3, 30'h3fffd4, 30'h3fffd5, 30'h7fffd9, 30'h3fffd6, 30'h7fffda,
    30'h7fffdb, 30'h7fffdc, 30'h7fffdd, 30'h7fffde, 30'hffffeb, 30'h7fffdf,
    30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0, 30'hffffee, 30'h7fffe1,
    30'h7fffe2, 30'h7fffe3, 30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5,
    30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef, 30'h3fffda, 30'h1fffdd,
    30'hfffe9, 30'h3fffdb, 30'h3fffdc, 30'h7fffe8, 30'h7fffe9, 30'h1fffde,
    30'h7fffea, 30'h3fffdd, 30'h3fffde, 30'hfffff0, 30'h1fffdf, 30'h3fffdf,
    30'h7fffeb, 30'h7fffec, 30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2,
    30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef, 30'hfffea, 30'h3fffe2,
    30'h3fffe3, 30'h3fffe4, 30'h7ffff0, 30'h3fffe5, 30'h3fffe6, 30'h7ffff1,
    30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1, 30'h3fffe7, 30'h7ffff2,
    30'h3fffe8, 30'h1ffffec, 30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde,
    30'h7ffffdf, 30'h3ffffe5, 30'hfffff1, 30'h1ffffed, 30'h7fff2, 30'h1fffe3,
    30'h3ffffe6, 30'h7ffffe0, 30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2, 30'hfffff2,
    30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9, 30'hffffffd, 30'h7ffffe3,
    30'h7ffffe4, 30'h7ffffe5, 30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6,
    30'h3fffe9, 30'h1fffe7, 30'h1fffe8, 30'h7ffff3, 30'h3fffea, 30'h3fffeb,
    30'h1ffffee, 30'h1ffffef, 30'hfffff4, 30'hfffff5, 30'h3ffffea, 30'h7ffff4,
    30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed, 30'h7ffffe7, 30'h7ffffe8,
    30'h7ffffe9, 30'h7ffffea, 30'h7ffffeb, 30'hffffffe, 30'h7ffffec, 30'h7ffffed,
    30'h7ffffee, 30'h7ffffef, 30'h7fffff0, 30'h3ffffee
  };

  localparam logic [LenW-1:0] HuffLen [256] = '{
    13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
    28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
     6, 10, 10, 12, 13,  6,  8, 11, 10, 10,  8, 11,  8,  6,  6,  6,
     5,  5,  5,  6,  6,  6,  6,  6,  6,  6,  7,  8, 15,  6, 12, 10,
    13,  6,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,
     7,  7,  7,  7,  7,  7,  7,  7,  8,  7,  8, 13, 19, 13, 14,  6,
    15,  5,  6,  5,  6,  5,  6,  6,  6,  5,  7,  7,  6,  6,  6,  5,
     6,  7,  6,  5,  5,  6,  7,  7,  7,  7,  7, 15, 11, 14, 13, 28,
    20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
    24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
    22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
    21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
    26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
    19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
    20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
    26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
  };

endpackage

/* rtl/hpk_sym_if.sv */
interface hpk_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] sym_byte;
  logic       sym_last;
  modport source (output valid, sym_byte, sym_last, input ready);
  modport sink (input valid, sym_byte, sym_last, output ready);
endinterface

/* rtl/hpk_code_if.sv */
interface hpk_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       code_last;
  modport source (output valid, code_byte, code_last, input ready);
  modport sink (input valid, code_byte, code_last, output ready);
endinterface

/* rtl/hpk_rom.sv */
module hpk_rom (
  input  logic                clk,
  input  logic                en,
  input  logic [7:0]          addr,
  output hpk_pkg::rom_entry_t rdata
);

  always_ff @(posedge clk) begin
    if (en) begin
      rdata.code <= hpk_pkg::HuffCode[addr];
      rdata.len  <= hpk_pkg::HuffLen[addr];
    end
  end

endmodule

/* rtl/hpack_huffman_encoder.sv */
// hpack huffman string encoder
// sym: one string octet per beat, sym_last on the final octet
// code: packed coded octets msb first, code_last on the final octet of a string
// an accepted octet is looked up in a registered code rom,
// then joined to up to 7 pending bits in a bit accumulator
// the accumulator sends one octet per cycle while the receiver takes it;
// an octet code of n bits gives 0 to 5 output beats and holds the
// accumulator for its load and for each output beat, so a byte is
// accepted every cycle only while codes leave no full octet to send
// the first output beat passes the rom register, the accumulator and the output register
// the lookup stage holds while the accumulator still has octets to send,
// and input ready drops only when both lookup and accumulator are busy
// on the last octet, leftover bits are padded with ones and the pending
// state clears for the next string
// reset clears all valid flags and pending bits; a stalled receiver
// holds the output register and backs up into the input channel
module hpack_huffman_encoder (
  input logic        clk,
  input logic        rst,
  hpk_sym_if.sink    sym,
  hpk_code_if.source code
);

  localparam int unsigned AccW = hpk_pkg::AccW;
  localparam int unsigned CntW = hpk_pkg::CntW;

  hpk_pkg::rom_entry_t rom_q;
  logic                lk_valid;
  logic                lk_last;
  logic                rom_en;

  logic [AccW-1:0]     acc;
  logic [CntW-1:0]     cnt;
  logic                acc_last;
  logic                acc_busy;
  logic                load;
  logic                emit;
  logic                out_free;
  logic [AccW-1:0]     acc_join;
  logic [CntW-1:0]     cnt_join;
  logic [CntW-1:0]     cnt_sh;
  logic [AccW-1:0]     acc_sh;
  logic [7:0]          top_byte;
  logic [7:0]          pad_mask;
  logic                is_final;

  // accumulator busy while it still holds a full octet or a last tail
  assign acc_busy = (cnt >= CntW'(8)) || (acc_last && (cnt != '0));
  assign out_free = !code.valid || code.ready;
  assign load     = lk_valid && !acc_busy;
  assign rom_en   = sym.valid && sym.ready;
  assign sym.ready = !lk_valid || load;

  hpk_rom u_rom (
    .clk   (clk),
    .en    (rom_en),
    .addr  (sym.sym_byte),
    .rdata (rom_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lk_valid <= 1'b0;
    end else if (sym.ready) begin
      lk_valid <= sym.valid;
    end
    if (rom_en) begin
      lk_last <= sym.sym_last;
    end
  end

  assign acc_join = (acc << rom_q.len) | AccW'(rom_q.code);
  assign cnt_join = cnt + CntW'(rom_q.len);

  // octet at the top of the valid bits
  assign cnt_sh   = (cnt >= CntW'(8)) ? cnt - CntW'(8) : '0;
  assign acc_sh   = (cnt >= CntW'(8)) ? (acc >> cnt_sh) : (acc << (CntW'(8) - cnt));
  assign pad_mask = (cnt >= CntW'(8)) ? 8'h00 : (8'hff >> cnt);
  assign top_byte = acc_sh[7:0] | pad_mask;
  assign is_final = acc_last && ((cnt == CntW'(8)) || (cnt < CntW'(8)));
  assign emit     = acc_busy && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      cnt      <= '0;
      acc_last <= 1'b0;
    end else if (load) begin
      acc      <= acc_join;
      cnt      <= cnt_join;
      acc_last <= lk_last;
    end else if (emit) begin
      cnt <= cnt_sh;
      if (cnt <= CntW'(8) && acc_last) begin
        acc_last <= 1'b0;
        cnt      <= '0;
      end
      acc <= acc & ((AccW'(1) << cnt_sh) - AccW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code.valid <= 1'b0;
    end else if (out_free) begin
      code.valid <= acc_busy;
    end
    if (emit) begin
      code.code_byte <= top_byte;
      code.code_last <= is_final && (cnt <= CntW'(8));
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [7:0] sym_byte;
    logic       sym_last;
  } sym_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hpk_sym_if  sym ();
  hpk_code_if code ();

  hpack_huffman_encoder dut (
    .clk  (clk),
    .rst  (rst),
    .sym  (sym.sink),
    .code (code.source)
  );

  always #10 clk = ~clk;

  sym_item_t sym_queue[$];
  hpk_pkg::out_beat_t coded_expect[$];
  logic [6:0] pend_bits = '0;
  int unsigned pend_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit drain_pause;
  bit hold_req;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;

  // predict the packed octets caused by one accepted symbol
  task automatic encode_sym(input logic [7:0] b, input logic last);
    logic [63:0] acc;
    int unsigned total;
    int unsigned pad;
    int unsigned first;
    hpk_pkg::out_beat_t beat;
    acc = 64'(pend_bits) & ((64'd1 << pend_cnt) - 1);
    acc = (acc << hpk_pkg::HuffLen[b]) | 64'(hpk_pkg::HuffCode[b]);
    total = pend_cnt + hpk_pkg::HuffLen[b];
    first = coded_expect.size();
    while (total >= 8) begin
      total -= 8;
      beat.code_byte = 8'(acc >> total);
      beat.code_last = 1'b0;
      coded_expect.insert(coded_expect.size(), beat);
    end
    if (last) begin
      if (total > 0) begin
        pad = 8 - total;
        beat.code_byte = 8'((acc << pad) | ((64'd1 << pad) - 1));
        beat.code_last = 1'b0;
        coded_expect.insert(coded_expect.size(), beat);
      end
      if (coded_expect.size() > first)
        coded_expect[coded_expect.size()-1].code_last = 1'b1;
      pend_bits = '0;
      pend_cnt = 0;
    end else begin
      pend_cnt = total;
      pend_bits = 7'(acc & ((64'd1 << total) - 1));
    end
  endtask

  task automatic add_sym(input logic [7:0] b, input logic last);
    sym_item_t it;
    it.sym_byte = b;
    it.sym_last = last;
    sym_queue.insert(sym_queue.size(), it);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      sym.valid <= 1'b0;
      sym.sym_byte <= '0;
      sym.sym_last <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      sym_item_t nxt;
      bit fire;
      bit busy;
      fire = sym.valid && sym.ready;
      if (fire) encode_sym(sym.sym_byte, sym.sym_last);
      busy = sym.valid && !fire;
      if (!busy) begin
        if (gap_left > 0 || drain_pause || sym_queue.size() == 0) begin
          sym.valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          nxt = sym_queue.pop_front();
          sym.valid <= 1'b1;
          sym.sym_byte <= nxt.sym_byte;
          sym.sym_last <= nxt.sym_last;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (rst) begin
      code.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left <= 300;
      code.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      code.ready <= (hold_left == 1);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      code.ready <= 1'b0;
    end else begin
      code.ready <= 1'b1;
      if ((cycles % 200) > 100 && $urandom_range(0, 4) == 0)
        stall_left <= $urandom_range(1, 8);
    end
  end

  // monitor
  always @(posedge clk) begin
    hpk_pkg::out_beat_t exp_beat;
    if (!rst && code.valid && code.ready) begin
      if (coded_expect.size() == 0) begin
        $error("unexpected beat: code_byte %h code_last %b", code.code_byte, code.code_last);
        errors++;
      end else begin
        exp_beat = coded_expect.pop_front();
        if (code.code_byte !== exp_beat.code_byte) begin
          $error("code_byte expected %h actual %h", exp_beat.code_byte, code.code_byte);
          errors++;
        end
        if (code.code_last !== exp_beat.code_last) begin
          $error("code_last expected %b actual %b", exp_beat.code_last, code.code_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("hpack_huffman_encoder verification failed");
      $finish;
    end
  end

  task automatic add_string(input int unsigned len);
    int unsigned k;
    logic [7:0] b;
    for (k = 0; k < len; k++) begin
      case ($urandom_range(0, 9))
        0, 1: b = 8'($urandom_range(0, 255));
        2: b = 8'($urandom_range(128, 255));
        3: b = 8'($urandom_range(0, 31));
        default: b = 8'($urandom_range(32, 126));
      endcase
      add_sym(b, k == len - 1);
    end
  endtask

  initial begin
    int unsigned n;
    drain_pause = 0;
    hold_req = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: shortest codes, longest codes, exact fill, padding, one-octet strings
    add_sym(8'h30, 1'b1);
    add_sym(8'hff, 1'b1);
    add_sym(8'h00, 1'b1);
    add_sym(8'h0a, 1'b0);
    add_sym(8'h0d, 1'b0);
    add_sym(8'h16, 1'b1);
    add_sym(8'h61, 1'b0);
    add_sym(8'h30, 1'b0);
    add_sym(8'h30, 1'b0);
    add_sym(8'h30, 1'b0);
    add_sym(8'h30, 1'b0);
    add_sym(8'h30, 1'b0);
    add_sym(8'h30, 1'b0);
    add_sym(8'h30, 1'b1);
    add_sym(8'h26, 1'b1);
    add_sym(8'h80, 1'b0);
    add_sym(8'h55, 1'b0);
    add_sym(8'haa, 1'b1);
    add_sym(8'h7f, 1'b0);
    add_sym(8'h01, 1'b1);

    n = 20;
    while (n < 200) begin
      n += 1;
      add_string($urandom_range(1, 12));
      n += 0;
      n = n + 0;
      n = n + ($urandom_range(0, 0));
      n = n + 5;
    end
    wait (sym_queue.size() == 0 && coded_expect.size() == 0);
    @(posedge clk);

    // sender pauses until all output has drained
    drain_pause = 1;
    wait (coded_expect.size() == 0 && !sym.valid);
    repeat (8) @(posedge clk);
    drain_pause = 0;

    // receiver holds off while long codes keep coming
    for (n = 0; n < 40; n++) add_sym(8'($urandom_range(128, 255)), n == 39);
    hold_req = 1;
    wait (hold_left != 0);
    hold_req = 0;

    n = 0;
    while (n < 160) begin
      n += 1;
      add_string($urandom_range(1, 8));
      n += 4;
    end
    wait (sym_queue.size() == 0 && !sym.valid && coded_expect.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && coded_expect.size() == 0)
      $display("hpack_huffman_encoder verification clean");
    else
      $display("hpack_huffman_encoder verification failed");
    $finish;
  end

endmodule

/* files.f */
rtl/hpk_pkg.sv
rtl/hpk_sym_if.sv
rtl/hpk_code_if.sv
rtl/hpk_rom.sv
rtl/hpack_huffman_encoder.sv
tb/tb_top.sv
